### hdl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, event codes, register indexes and reset values for the
// button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  typedef logic [2:0] ev_t;

  localparam ev_t EV_NONE    = 3'd0;
  localparam ev_t EV_PRESS   = 3'd1;
  localparam ev_t EV_RELEASE = 3'd2;
  localparam ev_t EV_SINGLE  = 3'd3;
  localparam ev_t EV_DOUBLE  = 3'd4;
  localparam ev_t EV_LONG1   = 3'd5;
  localparam ev_t EV_LONG2   = 3'd6;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ACK    = 1'b1;

  localparam int MAP_BITS = 48;
  localparam int WIN_BITS = 16;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_FUNCTION_MAP = 3'd0;
  localparam reg_idx_t REG_SINGLE_WIN   = 3'd1;
  localparam reg_idx_t REG_DOUBLE_WIN   = 3'd2;
  localparam reg_idx_t REG_LONG_ONE     = 3'd3;
  localparam reg_idx_t REG_LONG_TWO     = 3'd4;
  localparam reg_idx_t REG_HOLD_FLAG    = 3'd5;

  localparam logic [WIN_BITS-1:0] SINGLE_WIN_RST = 16'd800;
  localparam logic [WIN_BITS-1:0] DOUBLE_WIN_RST = 16'd0;
  localparam logic [WIN_BITS-1:0] LONG_ONE_RST   = 16'd10000;
  localparam logic [WIN_BITS-1:0] LONG_TWO_RST   = 16'd20000;
  localparam logic [WIN_BITS-1:0] HOLD_FLAG_RST  = 16'd5000;

  typedef struct packed {
    logic [MAP_BITS-1:0] function_map;
    logic [WIN_BITS-1:0] single_window_ms;
    logic [WIN_BITS-1:0] double_window_ms;
    logic [WIN_BITS-1:0] long_one_ms;
    logic [WIN_BITS-1:0] long_two_ms;
    logic [WIN_BITS-1:0] hold_flag_ms;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic        pin_level;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       fired;
    ev_t        event_code;
    logic [7:0] function_code;
    logic       long_hold;
    logic       pressed;
  } out_item_t;

  function automatic logic [7:0] func_of(logic [MAP_BITS-1:0] fmap, ev_t ev);
    logic [7:0] code;
    code = 8'd0;
    case (ev)
      EV_PRESS:   code = fmap[7:0];
      EV_RELEASE: code = fmap[15:8];
      EV_SINGLE:  code = fmap[23:16];
      EV_DOUBLE:  code = fmap[31:24];
      EV_LONG1:   code = fmap[39:32];
      EV_LONG2:   code = fmap[47:40];
      default:    code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

### hdl/bgc_cfg.sv
// ----------------------------------------------------------------------------
// bgc_cfg
// Configuration register file: function map and the five time windows.
// ----------------------------------------------------------------------------
module bgc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  bgc_pkg::reg_idx_t              cfg_index,
  input  logic [bgc_pkg::MAP_BITS-1:0]   cfg_data,
  output bgc_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.function_map     <= '0;
      cfg.single_window_ms <= bgc_pkg::SINGLE_WIN_RST;
      cfg.double_window_ms <= bgc_pkg::DOUBLE_WIN_RST;
      cfg.long_one_ms      <= bgc_pkg::LONG_ONE_RST;
      cfg.long_two_ms      <= bgc_pkg::LONG_TWO_RST;
      cfg.hold_flag_ms     <= bgc_pkg::HOLD_FLAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bgc_pkg::REG_FUNCTION_MAP: cfg.function_map     <= cfg_data;
        bgc_pkg::REG_SINGLE_WIN:   cfg.single_window_ms <= cfg_data[bgc_pkg::WIN_BITS-1:0];
        bgc_pkg::REG_DOUBLE_WIN:   cfg.double_window_ms <= cfg_data[bgc_pkg::WIN_BITS-1:0];
        bgc_pkg::REG_LONG_ONE:     cfg.long_one_ms      <= cfg_data[bgc_pkg::WIN_BITS-1:0];
        bgc_pkg::REG_LONG_TWO:     cfg.long_two_ms      <= cfg_data[bgc_pkg::WIN_BITS-1:0];
        bgc_pkg::REG_HOLD_FLAG:    cfg.hold_flag_ms     <= cfg_data[bgc_pkg::WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/bgc_core.sv
// ----------------------------------------------------------------------------
// bgc_core
// Gesture state (level, press stamp, latched and pending events, hold flag)
// and the combinational classification of one beat.
// ----------------------------------------------------------------------------
module bgc_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  bgc_pkg::in_item_t   item,
  input  bgc_pkg::cfg_t       cfg,
  output bgc_pkg::out_item_t  result
);

  logic                 last_level, last_level_next;
  bgc_pkg::ev_t         latched_event, latched_event_next;
  bgc_pkg::ev_t         pending_event, pending_event_next;
  logic [TIME_BITS-1:0] press_stamp, press_stamp_next;
  logic                 hold_flag, hold_flag_next;

  logic [63:0]          now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] single_win, double_win, long_one, long_two, hold_win;
  logic                 dbl_mapped;

  assign now_wide   = {32'd0, item.now_ms};
  assign now_t      = now_wide[TIME_BITS-1:0];
  assign elapsed    = now_t - press_stamp;
  assign single_win = TIME_BITS'(cfg.single_window_ms);
  assign double_win = TIME_BITS'(cfg.double_window_ms);
  assign long_one   = TIME_BITS'(cfg.long_one_ms);
  assign long_two   = TIME_BITS'(cfg.long_two_ms);
  assign hold_win   = TIME_BITS'(cfg.hold_flag_ms);
  assign dbl_mapped = bgc_pkg::func_of(cfg.function_map, bgc_pkg::EV_DOUBLE) != 8'd0;

  always_comb begin
    last_level_next    = last_level;
    latched_event_next = latched_event;
    pending_event_next = pending_event;
    press_stamp_next   = press_stamp;
    hold_flag_next     = hold_flag;
    if (item.op == bgc_pkg::OP_ACK) begin
      latched_event_next = bgc_pkg::EV_NONE;
    end else if (item.pin_level != last_level) begin
      if (item.pin_level) begin
        if (cfg.double_window_ms != '0 && dbl_mapped && elapsed < double_win) begin
          pending_event_next = bgc_pkg::EV_DOUBLE;
          latched_event_next = bgc_pkg::EV_DOUBLE;
        end else if (bgc_pkg::func_of(cfg.function_map, bgc_pkg::EV_PRESS) != 8'd0) begin
          pending_event_next = bgc_pkg::EV_PRESS;
          latched_event_next = bgc_pkg::EV_PRESS;
        end
        press_stamp_next = now_t;
      end else begin
        // a release that ends a double press makes no event
        if (pending_event != bgc_pkg::EV_DOUBLE) begin
          if (cfg.single_window_ms != '0 && elapsed < single_win &&
              bgc_pkg::func_of(cfg.function_map, bgc_pkg::EV_SINGLE) != 8'd0) begin
            pending_event_next = bgc_pkg::EV_SINGLE;
            if (!dbl_mapped) latched_event_next = bgc_pkg::EV_SINGLE;
          end else if (bgc_pkg::func_of(cfg.function_map, bgc_pkg::EV_RELEASE) != 8'd0) begin
            pending_event_next = bgc_pkg::EV_RELEASE;
            if (!dbl_mapped) latched_event_next = bgc_pkg::EV_RELEASE;
          end
        end
        hold_flag_next = 1'b0;
      end
      last_level_next = item.pin_level;
    end else if (item.pin_level) begin
      if (bgc_pkg::func_of(cfg.function_map, bgc_pkg::EV_LONG2) != 8'd0 &&
          elapsed > long_two) begin
        if (pending_event != bgc_pkg::EV_LONG2) begin
          pending_event_next = bgc_pkg::EV_LONG2;
          latched_event_next = bgc_pkg::EV_LONG2;
        end
      end else if (bgc_pkg::func_of(cfg.function_map, bgc_pkg::EV_LONG1) != 8'd0 &&
                   elapsed > long_one) begin
        if (pending_event != bgc_pkg::EV_LONG1) begin
          pending_event_next = bgc_pkg::EV_LONG1;
          latched_event_next = bgc_pkg::EV_LONG1;
        end
      end
      if (elapsed > hold_win) hold_flag_next = 1'b1;
    end else if (pending_event != bgc_pkg::EV_NONE && dbl_mapped && elapsed > double_win) begin
      // double window ran out while released: release the held event
      if (pending_event == bgc_pkg::EV_SINGLE || pending_event == bgc_pkg::EV_RELEASE) begin
        latched_event_next = pending_event;
      end
      pending_event_next = bgc_pkg::EV_NONE;
    end
  end

  always_comb begin
    result.fired         = item.op == bgc_pkg::OP_SAMPLE && latched_event_next > latched_event;
    result.event_code    = latched_event_next;
    result.function_code = bgc_pkg::func_of(cfg.function_map, latched_event_next);
    result.long_hold     = hold_flag_next;
    result.pressed       = last_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b0;
      latched_event <= bgc_pkg::EV_NONE;
      pending_event <= bgc_pkg::EV_NONE;
      press_stamp   <= '0;
      hold_flag     <= 1'b0;
    end else if (step) begin
      last_level    <= last_level_next;
      latched_event <= latched_event_next;
      pending_event <= pending_event_next;
      press_stamp   <= press_stamp_next;
      hold_flag     <= hold_flag_next;
    end
  end

`ifndef SYNTH
  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.op == bgc_pkg::OP_ACK |=> latched_event == bgc_pkg::EV_NONE)
    else $error("acknowledge did not clear latched event");

  a_fired_event: assert property (@(posedge clk) disable iff (rst)
    step && result.fired |=> latched_event != bgc_pkg::EV_NONE)
    else $error("fired with no latched event");

  a_hold_pressed: assert property (@(posedge clk) disable iff (rst)
    hold_flag |-> last_level)
    else $error("hold flag set while released");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    latched_event <= bgc_pkg::EV_LONG2 && pending_event <= bgc_pkg::EV_LONG2)
    else $error("event code out of range");
`endif

endmodule

### hdl/button_gesture_classifier_unit.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier_unit
// Push-button gesture classifier: press, release, single, double and long
// presses from polled pin samples with millisecond timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carry one sample or acknowledge beat; a beat is
//   taken at an edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_item carry one result beat per input beat, in
//   order. Configuration is written through cfg_we/cfg_index/cfg_data; the
//   user must write it only while no beat is in flight, as the block does
//   not enforce this; unknown indexes are ignored. A taken beat lands in
//   the input register, is classified and goes to the output register
//   (out_item) once that is free. Throughput: one beat per cycle while
//   out_stall is low; the only loop is the registered gesture state.
//   A stalled result holds in the output register; the input register still
//   takes a beat, and in_stall rises only once both registers are full.
//   Reset clears both registers, the gesture state and loads the default
//   windows; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module button_gesture_classifier_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bgc_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bgc_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  bgc_pkg::reg_idx_t             cfg_index,
  input  logic [bgc_pkg::MAP_BITS-1:0]  cfg_data
);

  logic               a_valid;
  bgc_pkg::in_item_t  a_item;
  logic               b_load;
  bgc_pkg::cfg_t      cfg;
  bgc_pkg::out_item_t result;

  assign b_load    = a_valid && (!out_valid || !out_stall);
  assign in_stall  = a_valid && !b_load;

  bgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgc_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (b_load),
    .item   (a_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
      if (b_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) a_item <= in_item;
    if (b_load) out_item <= result;
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button gesture classifier. A directed table
// covers reset behavior, the timestamp wrap, acknowledge, double press,
// long presses, remapping and ignored register writes. Random phases follow,
// each with its own register setting. They play press/hold/release gestures
// with random timing, plus noise. Both sides of the stream idle at random.
// Each result beat is checked against a pinned expectation or an in-bench classifier.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 10;
  localparam int BEATS_PER_PHASE = 130;

  localparam bgc_pkg::reg_idx_t REG_SPARE_A = 3'd6;
  localparam bgc_pkg::reg_idx_t REG_SPARE_B = 3'd7;

  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_BURSTY = 3;

  localparam int CFG_TUNED   = 0;
  localparam int CFG_ZERO    = 1;
  localparam int CFG_MAX     = 2;
  localparam int CFG_DEFAULT = 3;
  localparam int CFG_WILD    = 4;

  typedef struct packed {
    logic               pinned;
    bgc_pkg::out_item_t want;
  } answer_t;

  typedef struct packed {
    logic                         is_write;
    bgc_pkg::reg_idx_t            idx;
    logic [bgc_pkg::MAP_BITS-1:0] data;
    bgc_pkg::in_item_t            beat;
    logic                         pinned;
    bgc_pkg::out_item_t           want;
  } step_row_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  bgc_pkg::in_item_t            in_item;
  logic                         out_valid;
  logic                         out_stall;
  bgc_pkg::out_item_t           out_item;
  logic                         cfg_we;
  bgc_pkg::reg_idx_t            cfg_index;
  logic [bgc_pkg::MAP_BITS-1:0] cfg_data;

  button_gesture_classifier_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register mirror
  logic [bgc_pkg::MAP_BITS-1:0] code_map;
  logic [bgc_pkg::WIN_BITS-1:0] single_win;
  logic [bgc_pkg::WIN_BITS-1:0] double_win;
  logic [bgc_pkg::WIN_BITS-1:0] long_one;
  logic [bgc_pkg::WIN_BITS-1:0] long_two;
  logic [bgc_pkg::WIN_BITS-1:0] hold_after;

  // gesture state mirror
  logic         level_q;
  bgc_pkg::ev_t latched_q;
  bgc_pkg::ev_t pending_q;
  logic [31:0]  stamp_q;
  logic         hold_q;

  bgc_pkg::out_item_t expected_gestures[$];
  answer_t            pinned_answers[$];
  step_row_t          directed_rows[$];

  int errors;
  int cycles;
  int beats_sent;
  int burst_left;
  int gap_max;
  int stall_mode;
  int holdoff_req;
  int hold_left;
  int stall_tick;
  logic [31:0] clock_ms;

  bgc_pkg::out_item_t predicted;
  bgc_pkg::out_item_t got;
  bgc_pkg::out_item_t want;
  answer_t            tag;

  function automatic logic [7:0] mapped_code(bgc_pkg::ev_t ev);
    int unsigned k;
    k = 32'(ev);
    if (ev < bgc_pkg::EV_PRESS || ev > bgc_pkg::EV_LONG2) return 8'd0;
    return code_map[8*(k-1) +: 8];
  endfunction

  function automatic bgc_pkg::out_item_t classify_sample(bgc_pkg::in_item_t it);
    logic [31:0]        elapsed;
    bgc_pkg::ev_t       prior;
    logic               dbl_on;
    bgc_pkg::out_item_t res;
    elapsed = it.now_ms - stamp_q;
    prior   = latched_q;
    dbl_on  = mapped_code(bgc_pkg::EV_DOUBLE) != 8'd0;
    if (it.op == bgc_pkg::OP_ACK) begin
      latched_q = bgc_pkg::EV_NONE;
    end else if (it.pin_level != level_q) begin
      if (it.pin_level) begin
        if (double_win != 0 && dbl_on && elapsed < double_win) begin
          pending_q = bgc_pkg::EV_DOUBLE;
          latched_q = bgc_pkg::EV_DOUBLE;
        end else if (mapped_code(bgc_pkg::EV_PRESS) != 8'd0) begin
          pending_q = bgc_pkg::EV_PRESS;
          latched_q = bgc_pkg::EV_PRESS;
        end
        stamp_q = it.now_ms;
      end else begin
        // the release of a double press makes no event of its own
        if (pending_q != bgc_pkg::EV_DOUBLE) begin
          if (single_win != 0 && mapped_code(bgc_pkg::EV_SINGLE) != 8'd0 &&
              elapsed < single_win) begin
            pending_q = bgc_pkg::EV_SINGLE;
            if (!dbl_on) latched_q = bgc_pkg::EV_SINGLE;
          end else if (mapped_code(bgc_pkg::EV_RELEASE) != 8'd0) begin
            pending_q = bgc_pkg::EV_RELEASE;
            if (!dbl_on) latched_q = bgc_pkg::EV_RELEASE;
          end
        end
        hold_q = 1'b0;
      end
      level_q = it.pin_level;
    end else if (it.pin_level) begin
      if (mapped_code(bgc_pkg::EV_LONG2) != 8'd0 && elapsed > long_two) begin
        if (pending_q != bgc_pkg::EV_LONG2) begin
          pending_q = bgc_pkg::EV_LONG2;
          latched_q = bgc_pkg::EV_LONG2;
        end
      end else if (mapped_code(bgc_pkg::EV_LONG1) != 8'd0 && elapsed > long_one) begin
        if (pending_q != bgc_pkg::EV_LONG1) begin
          pending_q = bgc_pkg::EV_LONG1;
          latched_q = bgc_pkg::EV_LONG1;
        end
      end
      if (elapsed > hold_after) hold_q = 1'b1;
    end else if (pending_q != bgc_pkg::EV_NONE && dbl_on && elapsed > double_win) begin
      // double window ran out while released: commit what was held back
      if (pending_q == bgc_pkg::EV_SINGLE) latched_q = bgc_pkg::EV_SINGLE;
      else if (pending_q == bgc_pkg::EV_RELEASE) latched_q = bgc_pkg::EV_RELEASE;
      pending_q = bgc_pkg::EV_NONE;
    end
    res.fired         = (it.op == bgc_pkg::OP_SAMPLE) && (latched_q > prior);
    res.event_code    = latched_q;
    res.function_code = mapped_code(latched_q);
    res.long_hold     = hold_q;
    res.pressed       = level_q;
    return res;
  endfunction

  function automatic step_row_t sample_row(logic op, logic pin, logic [31:0] t);
    step_row_t r;
    r = '0;
    r.beat.op        = op;
    r.beat.pin_level = pin;
    r.beat.now_ms    = t;
    return r;
  endfunction

  function automatic step_row_t known_row(logic op, logic pin, logic [31:0] t,
                                          bgc_pkg::out_item_t res);
    step_row_t r;
    r = sample_row(op, pin, t);
    r.pinned = 1'b1;
    r.want   = res;
    return r;
  endfunction

  function automatic step_row_t reg_row(bgc_pkg::reg_idx_t idx,
                                        logic [bgc_pkg::MAP_BITS-1:0] data);
    step_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.data     = data;
    return r;
  endfunction

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_gestures.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (holdoff_req != 0) begin
      hold_left   = holdoff_req;
      holdoff_req = 0;
    end
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        STALL_BURSTY: out_stall <= (stall_tick % 8) < 5;
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predicted = classify_sample(in_item);
        if (pinned_answers.size() != 0) tag = pinned_answers.pop_front();
        else tag = '0;
        expected_gestures.push_back(tag.pinned ? tag.want : predicted);
      end
      if (out_valid && !out_stall) begin
        got = out_item;
        if (expected_gestures.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = expected_gestures.pop_front();
          if (got.fired !== want.fired || got.event_code !== want.event_code ||
              got.function_code !== want.function_code ||
              got.long_hold !== want.long_hold || got.pressed !== want.pressed) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at cycle %0d: expected fired=%0b ev=%0d fn=%02h hold=%0b",
                       cycles, want.fired, want.event_code, want.function_code,
                       want.long_hold);
              $display("  expected pressed=%0b, got fired=%0b ev=%0d fn=%02h hold=%0b",
                       want.pressed, got.fired, got.event_code, got.function_code,
                       got.long_hold);
              $display("  got pressed=%0b", got.pressed);
            end
          end
        end
      end
    end
  end

  task automatic offer(bgc_pkg::in_item_t it, logic pinned, bgc_pkg::out_item_t res);
    int gap;
    answer_t a;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    a.pinned = pinned;
    a.want   = res;
    @(negedge clk);
    pinned_answers.push_back(a);
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    beats_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_gestures.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(bgc_pkg::reg_idx_t idx,
                           logic [bgc_pkg::MAP_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      bgc_pkg::REG_FUNCTION_MAP: code_map   = data;
      bgc_pkg::REG_SINGLE_WIN:   single_win = data[bgc_pkg::WIN_BITS-1:0];
      bgc_pkg::REG_DOUBLE_WIN:   double_win = data[bgc_pkg::WIN_BITS-1:0];
      bgc_pkg::REG_LONG_ONE:     long_one   = data[bgc_pkg::WIN_BITS-1:0];
      bgc_pkg::REG_LONG_TWO:     long_two   = data[bgc_pkg::WIN_BITS-1:0];
      bgc_pkg::REG_HOLD_FLAG:    hold_after = data[bgc_pkg::WIN_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [bgc_pkg::MAP_BITS-1:0] sparse_map();
    logic [bgc_pkg::MAP_BITS-1:0] m;
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 5))
        0, 1:    m[8*k +: 8] = 8'h00;
        2:       m[8*k +: 8] = 8'hFF;
        default: m[8*k +: 8] = 8'($urandom_range(1, 255));
      endcase
    end
    return m;
  endfunction

  // writes every register for one phase, returns the time span to play in
  task automatic program_phase(int mode, output int span);
    logic [bgc_pkg::WIN_BITS-1:0] w[5];
    logic [bgc_pkg::MAP_BITS-1:0] m;
    m = sparse_map();
    case (mode)
      CFG_TUNED: begin
        w[0] = 16'($urandom_range(20, 600));
        w[1] = 16'($urandom_range(20, 600));
        w[2] = 16'($urandom_range(300, 3000));
        w[3] = 16'(w[2] + $urandom_range(0, 3000));
        w[4] = 16'($urandom_range(100, 3000));
      end
      CFG_ZERO: begin
        foreach (w[k]) w[k] = '0;
        m = '1;
      end
      CFG_MAX: begin
        foreach (w[k]) w[k] = '1;
      end
      CFG_DEFAULT: begin
        w[0] = bgc_pkg::SINGLE_WIN_RST;
        w[1] = bgc_pkg::DOUBLE_WIN_RST;
        w[2] = bgc_pkg::LONG_ONE_RST;
        w[3] = bgc_pkg::LONG_TWO_RST;
        w[4] = bgc_pkg::HOLD_FLAG_RST;
      end
      default: begin
        foreach (w[k]) w[k] = 16'($urandom_range(0, 65535));
        m = {16'($urandom_range(0, 65535)), $urandom()};
      end
    endcase
    write_reg(bgc_pkg::REG_FUNCTION_MAP, m);
    // upper bits of the narrow registers carry junk that must be dropped
    write_reg(bgc_pkg::REG_SINGLE_WIN, {$urandom(), w[0]});
    write_reg(bgc_pkg::REG_DOUBLE_WIN, {$urandom(), w[1]});
    write_reg(bgc_pkg::REG_LONG_ONE,   {$urandom(), w[2]});
    write_reg(bgc_pkg::REG_LONG_TWO,   {$urandom(), w[3]});
    write_reg(bgc_pkg::REG_HOLD_FLAG,  {$urandom(), w[4]});
    if ($urandom_range(0, 1))
      write_reg(REG_SPARE_B, {16'($urandom_range(0, 65535)), $urandom()});
    span = 64;
    foreach (w[k]) if (int'(w[k]) + 1 > span) span = int'(w[k]) + 1;
  endtask

  function automatic logic [31:0] step_ms(int span);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 50);
      3:       return $urandom_range(0, 2 * span);
      default: return $urandom_range(0, span);
    endcase
  endfunction

  task automatic send_sample(logic op, logic pin);
    bgc_pkg::in_item_t it;
    it.op        = op;
    it.pin_level = pin;
    it.now_ms    = clock_ms;
    offer(it, 1'b0, '0);
  endtask

  task automatic play_gesture(int span);
    int kind;
    int holds;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      // jump anywhere on the time line
      clock_ms = $urandom();
      send_sample(bgc_pkg::OP_SAMPLE, 1'($urandom_range(0, 1)));
    end else if (kind == 1) begin
      send_sample(bgc_pkg::OP_ACK, 1'($urandom_range(0, 1)));
    end else if (kind == 2) begin
      clock_ms += step_ms(span);
      send_sample(bgc_pkg::OP_SAMPLE, 1'($urandom_range(0, 1)));
    end else begin
      clock_ms += step_ms(span);
      send_sample(bgc_pkg::OP_SAMPLE, 1'b1);
      holds = $urandom_range(0, 3);
      repeat (holds) begin
        clock_ms += step_ms(span / 2);
        if ($urandom_range(0, 9) == 0) send_sample(bgc_pkg::OP_ACK, 1'b1);
        else send_sample(bgc_pkg::OP_SAMPLE, 1'b1);
      end
      clock_ms += step_ms(span / 2);
      send_sample(bgc_pkg::OP_SAMPLE, 1'b0);
      repeat ($urandom_range(0, 2)) begin
        clock_ms += step_ms(span);
        send_sample(bgc_pkg::OP_SAMPLE, 1'b0);
      end
    end
  endtask

  initial begin
    int span;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_item     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = bgc_pkg::REG_FUNCTION_MAP;
    cfg_data    = '0;
    code_map    = '0;
    single_win  = bgc_pkg::SINGLE_WIN_RST;
    double_win  = bgc_pkg::DOUBLE_WIN_RST;
    long_one    = bgc_pkg::LONG_ONE_RST;
    long_two    = bgc_pkg::LONG_TWO_RST;
    hold_after  = bgc_pkg::HOLD_FLAG_RST;
    level_q     = 1'b0;
    latched_q   = bgc_pkg::EV_NONE;
    pending_q   = bgc_pkg::EV_NONE;
    stamp_q     = '0;
    hold_q      = 1'b0;
    errors      = 0;
    cycles      = 0;
    beats_sent  = 0;
    burst_left  = 0;
    gap_max     = 2;
    stall_mode  = STALL_LIGHT;
    holdoff_req = 0;
    hold_left   = 0;
    stall_tick  = 0;
    clock_ms    = $urandom();

    // reset values, nothing mapped: only the level and hold flag move
    directed_rows.push_back(reg_row(bgc_pkg::REG_FUNCTION_MAP, '0));
    directed_rows.push_back(known_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'h0000_0000,
                                      '{1'b0, bgc_pkg::EV_NONE, 8'h00, 1'b0, 1'b0}));
    directed_rows.push_back(known_row(bgc_pkg::OP_SAMPLE, 1'b1, 32'hFFFF_FF00,
                                      '{1'b0, bgc_pkg::EV_NONE, 8'h00, 1'b0, 1'b1}));
    // held across the timestamp wrap, past the hold-flag time
    directed_rows.push_back(known_row(bgc_pkg::OP_SAMPLE, 1'b1, 32'h0000_1400,
                                      '{1'b0, bgc_pkg::EV_NONE, 8'h00, 1'b1, 1'b1}));
    directed_rows.push_back(known_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'hFFFF_FFFF,
                                      '{1'b0, bgc_pkg::EV_NONE, 8'h00, 1'b0, 1'b0}));
    directed_rows.push_back(known_row(bgc_pkg::OP_ACK, 1'b1, 32'h0000_0000,
                                      '{1'b0, bgc_pkg::EV_NONE, 8'h00, 1'b0, 1'b0}));
    // all six events mapped, double press enabled
    directed_rows.push_back(reg_row(bgc_pkg::REG_FUNCTION_MAP, 48'h06_05_04_03_02_FF));
    directed_rows.push_back(reg_row(bgc_pkg::REG_DOUBLE_WIN, 48'd300));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b1, 32'd1000));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'd1100));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b1, 32'd1250));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'd1400));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'd2000));
    directed_rows.push_back(sample_row(bgc_pkg::OP_ACK, 1'b0, 32'd2100));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b1, 32'd3000));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b1, 32'd14000));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b1, 32'd24000));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'd25000));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'd25100));
    // unmap single and release while release is latched
    directed_rows.push_back(reg_row(bgc_pkg::REG_FUNCTION_MAP, 48'h06_05_04_00_00_FF));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'd26000));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b1, 32'd30000));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'd30100));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'd30200));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'd30400));
    // spare index ignored, over-wide window masked
    directed_rows.push_back(reg_row(REG_SPARE_A, '1));
    directed_rows.push_back(reg_row(bgc_pkg::REG_SINGLE_WIN, 48'hFFFF_0000_0320));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b1, 32'hFFFF_FFFF));
    directed_rows.push_back(sample_row(bgc_pkg::OP_SAMPLE, 1'b0, 32'h0000_0010));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        drain_results();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        offer(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      program_phase(phase % (CFG_WILD + 1), span);
      stall_mode = phase % 4;
      gap_max    = (phase % 3 == 0) ? 0 : 1 + phase % 6;
      // long hold-off with the sender running flat out: both registers fill
      if (phase == 2) begin
        gap_max     = 0;
        holdoff_req = 400;
      end
      beats_sent = 0;
      while (beats_sent < BEATS_PER_PHASE) play_gesture(span);
    end

    drain_results();
    repeat (10) @(posedge clk);
    errors += expected_gestures.size();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### button_gesture_classifier_unit.f
hdl/bgc_pkg.sv
hdl/bgc_cfg.sv
hdl/bgc_core.sv
hdl/button_gesture_classifier_unit.sv
dv/tb.sv
